>>> design/ava_pkg.sv
// Package for the audio voice allocator: table entry layout, port structs
// between the controller and the table, and the scan constants.
// No dependencies.
`timescale 1ns / 1ps

package ava_pkg;

    localparam int MAX_SOURCES = 64;
    localparam int SLOT_W      = $clog2(MAX_SOURCES);
    localparam int SCAN_W      = SLOT_W + 1;
    localparam int CFG_W       = 7;
    localparam int COUNT_W     = 16;
    localparam int PRI_W       = 3;
    localparam int GAIN_W      = 16;
    localparam int TIME_W      = 32;
    localparam int LOOPS_W     = 8;

    // The weakest-voice record starts above any stored value.
    localparam int WPRI_W  = 10;
    localparam int WGAIN_W = 22;
    localparam logic [WPRI_W-1:0]  INIT_WEAK_PRI  = 10'd999;
    localparam logic [WGAIN_W-1:0] INIT_WEAK_GAIN = 22'd4096000;

    localparam logic [CFG_W-1:0] SOURCES_RESET = 7'd64;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef struct packed {
        logic               locked;
        logic               active;
        logic               playing;
        logic               looping;
        logic [PRI_W-1:0]   priority_val;
        logic [GAIN_W-1:0]  gain;
        logic [TIME_W-1:0]  time_ms;
        logic [LOOPS_W-1:0] loops;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

>>> design/ava_table.sv
// Voice table: one synchronous memory of entries with a registered read.
// Depends on ava_pkg; per-entry valid flops make unwritten entries read as zero.
`timescale 1ns / 1ps

module ava_table
    import ava_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  tbl_wr_t wr,
    input  tbl_rd_t rd,
    output entry_t  rd_data
);

    entry_t                 mem [MAX_SOURCES];
    logic [MAX_SOURCES-1:0] valid_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // An entry never written since reset reads as zero through its valid flag.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> design/ava_ctrl.sv
// Allocation controller: scan sequencer, weakest-voice record, write-back
// and the allocation counter. Depends on ava_pkg; drives ava_table.
`timescale 1ns / 1ps

module ava_ctrl
    import ava_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CFG_W-1:0]   cfg_write_data,
    input  logic               start,
    input  logic               mode,
    input  logic [SLOT_W-1:0]  entry_index,
    input  entry_t             entry_in,
    input  logic [PRI_W-1:0]   request_priority,
    input  logic [TIME_W-1:0]  now_time,
    output logic               idle,
    output tbl_wr_t            wr,
    output tbl_rd_t            rd,
    input  entry_t             rd_data,
    output logic               res_valid,
    input  logic               res_take,
    output result_t            res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WB   = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     sources_reg;
    logic [SCAN_W-1:0]    n_reg, n_next;
    logic [SCAN_W-1:0]    issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [PRI_W-1:0]     req_reg, req_next;
    logic [WPRI_W-1:0]    wpri_reg, wpri_next;
    logic [WGAIN_W-1:0]   wgain_reg, wgain_next;
    logic [TIME_W-1:0]    wtime_reg, wtime_next;
    logic [LOOPS_W-1:0]   wloops_reg, wloops_next;
    logic                 only_play_reg, only_play_next;
    logic                 have_weak_reg, have_weak_next;
    logic [SLOT_W-1:0]    weak_reg, weak_next;
    logic                 grant_reg, grant_next;
    logic [SLOT_W-1:0]    chosen_reg, chosen_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 pri_lt_req;
    logic                 pri_lt_w;
    logic                 gain_lt_w;
    logic                 time_lt_w;
    logic                 loops_gt_w;
    logic [SCAN_W-1:0]    n_start;

    always_comb
    begin
        pri_lt_req = rd_data.priority_val < req_reg;
        pri_lt_w   = {{(WPRI_W-PRI_W){1'b0}}, rd_data.priority_val} < wpri_reg;
        gain_lt_w  = {{(WGAIN_W-GAIN_W){1'b0}}, rd_data.gain} < wgain_reg;
        time_lt_w  = rd_data.time_ms < wtime_reg;
        loops_gt_w = rd_data.loops > wloops_reg;
        if (sources_reg > CFG_W'(MAX_SOURCES))
        begin
            n_start = SCAN_W'(MAX_SOURCES);
        end
        else
        begin
            n_start = SCAN_W'(sources_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        req_next       = req_reg;
        wpri_next      = wpri_reg;
        wgain_next     = wgain_reg;
        wtime_next     = wtime_reg;
        wloops_next    = wloops_reg;
        only_play_next = only_play_reg;
        have_weak_next = have_weak_reg;
        weak_next      = weak_reg;
        grant_next     = grant_reg;
        chosen_next    = chosen_reg;
        count_next     = count_reg;
        wr             = '0;
        rd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        wr.we       = 1'b1;
                        wr.addr     = entry_index;
                        wr.data     = entry_in;
                        grant_next  = 1'b0;
                        chosen_next = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        n_next         = n_start;
                        issue_next     = '0;
                        req_next       = request_priority;
                        wpri_next      = INIT_WEAK_PRI;
                        wgain_next     = INIT_WEAK_GAIN;
                        wtime_next     = now_time;
                        wloops_next    = '0;
                        only_play_next = 1'b1;
                        have_weak_next = 1'b0;
                        weak_next      = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads are issued one per cycle; the entry read last cycle is judged now.
                if (issue_reg < n_reg)
                begin
                    rd.en         = 1'b1;
                    rd.addr       = issue_reg[SLOT_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[SLOT_W-1:0];
                end
                if (pend_reg && !rd_data.locked)
                begin
                    if (!rd_data.active)
                    begin
                        grant_next  = 1'b1;
                        chosen_next = pend_idx_reg;
                        pend_next   = 1'b0;
                        state_next  = S_WB;
                    end
                    else if (rd_data.playing)
                    begin
                        if (only_play_reg && pri_lt_req &&
                            (pri_lt_w || (!rd_data.looping && (gain_lt_w || time_lt_w))))
                        begin
                            wpri_next      = {{(WPRI_W-PRI_W){1'b0}}, rd_data.priority_val};
                            wtime_next     = rd_data.time_ms;
                            wgain_next     = {{(WGAIN_W-GAIN_W){1'b0}}, rd_data.gain};
                            weak_next      = pend_idx_reg;
                            have_weak_next = 1'b1;
                        end
                    end
                    else
                    begin
                        only_play_next = 1'b0;
                        if (!have_weak_reg || loops_gt_w || pri_lt_w || time_lt_w)
                        begin
                            wpri_next      = {{(WPRI_W-PRI_W){1'b0}}, rd_data.priority_val};
                            wtime_next     = rd_data.time_ms;
                            wloops_next    = rd_data.loops;
                            weak_next      = pend_idx_reg;
                            have_weak_next = 1'b1;
                        end
                    end
                end
                if (!pend_reg && issue_reg == n_reg)
                begin
                    grant_next  = have_weak_reg;
                    chosen_next = have_weak_reg ? weak_reg : '0;
                    state_next  = S_WB;
                end
            end
            S_WB:
            begin
                if (grant_reg)
                begin
                    wr.we             = 1'b1;
                    wr.addr           = chosen_reg;
                    wr.data           = '0;
                    wr.data.active    = 1'b1;
                    count_next        = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sources_reg <= SOURCES_RESET;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (cfg_write_en)
            begin
                sources_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        req_reg       <= req_next;
        wpri_reg      <= wpri_next;
        wgain_reg     <= wgain_next;
        wtime_reg     <= wtime_next;
        wloops_reg    <= wloops_next;
        only_play_reg <= only_play_next;
        have_weak_reg <= have_weak_next;
        weak_reg      <= weak_next;
        grant_reg     <= grant_next;
        chosen_reg    <= chosen_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.granted = grant_reg;
    assign res.slot    = chosen_reg;
    assign res.count   = count_reg;

`ifndef SYNTHESIS
    a_wr_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (state_reg == S_IDLE || state_reg == S_WB))
        else $error("table written outside an entry write or write-back");

    a_rd_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd.en |-> (state_reg == S_SCAN))
        else $error("table read outside the scan");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= n_reg))
        else $error("scan read counter passed the scan length");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WB) |=> $stable(count_reg))
        else $error("allocation count moved outside write-back");

    a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.granted) |-> (res.slot == '0))
        else $error("slot not zero on a refused allocation");
`endif

endmodule

>>> design/audio_voice_allocator.sv
// Top level of the audio voice allocator: input and output handshakes,
// result register. Depends on ava_pkg, ava_table and ava_ctrl.
//
//   Channel   Signals                                   Direction
//   in        in_valid/in_ready, mode .. now_time       into block
//   out       out_valid/out_ready, granted/slot/count   out of block
//   cfg       cfg_write_en, cfg_write_data              into block
//
// An entry write passes from acceptance through S_DONE into the result register.
// An allocation scans at most n entries (n = scan length, capped at 64)
// through the single read port of the table: one entry is read per cycle.
// The scan stops early at the first free unlocked entry.
// Reset clears the table valid flags and the count, and sets the scan length (64).
// A result waits in the output register while the next transaction is accepted.
`timescale 1ns / 1ps

module audio_voice_allocator
    import ava_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CFG_W-1:0]   cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [SLOT_W-1:0]  entry_index,
    input  logic               entry_locked,
    input  logic               entry_active,
    input  logic               entry_playing,
    input  logic               entry_looping,
    input  logic [PRI_W-1:0]   entry_priority,
    input  logic [GAIN_W-1:0]  entry_gain,
    input  logic [TIME_W-1:0]  entry_time,
    input  logic [LOOPS_W-1:0] entry_loop_count,
    input  logic [PRI_W-1:0]   request_priority,
    input  logic [TIME_W-1:0]  now_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               granted,
    output logic [SLOT_W-1:0]  slot,
    output logic [COUNT_W-1:0] active_count
);

    tbl_wr_t wr;
    tbl_rd_t rd;
    entry_t  rd_data;
    entry_t  entry_in;
    result_t res;
    logic    idle;
    logic    res_valid;
    logic    res_take;
    logic    out_valid_reg;
    result_t out_reg;

    always_comb
    begin
        entry_in.locked       = entry_locked;
        entry_in.active       = entry_active;
        entry_in.playing      = entry_playing;
        entry_in.looping      = entry_looping;
        entry_in.priority_val = entry_priority;
        entry_in.gain         = entry_gain;
        entry_in.time_ms      = entry_time;
        entry_in.loops        = entry_loop_count;
    end

    assign in_ready = idle;
    assign res_take = !out_valid_reg || out_ready;

    ava_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    ava_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .start            (in_valid && idle),
        .mode             (mode),
        .entry_index      (entry_index),
        .entry_in         (entry_in),
        .request_priority (request_priority),
        .now_time         (now_time),
        .idle             (idle),
        .wr               (wr),
        .rd               (rd),
        .rd_data          (rd_data),
        .res_valid        (res_valid),
        .res_take         (res_take),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = out_reg.granted;
    assign slot         = out_reg.slot;
    assign active_count = out_reg.count;

endmodule

>>> verif/ava_tb_pkg.sv
// Scoreboard for the audio voice allocator testbench: request type, a model of
// the voice table and the queue of expected grants. Depends on ava_pkg.
`timescale 1ns / 1ps

package ava_tb_pkg;

    import ava_pkg::*;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  index;
        entry_t             entry;
        logic [PRI_W-1:0]   req_pri;
        logic [TIME_W-1:0]  now;
    } voice_req_t;

    class voice_scoreboard;

        entry_t              voices [MAX_SOURCES];
        logic [COUNT_W-1:0]  alloc_count;
        logic [CFG_W-1:0]    scan_len;
        result_t             grants_due [$];
        int unsigned         mismatches;

        function new();
            voices      = '{default: '0};
            alloc_count = '0;
            scan_len    = SOURCES_RESET;
            mismatches  = 0;
        endfunction

        function void set_scan_length(logic [CFG_W-1:0] value);
            scan_len = value;
        endfunction

        // Updates the table copy and returns the grant that the block should give.
        function result_t predict_allocation(voice_req_t r);
            result_t             res;
            int unsigned         span;
            logic [WPRI_W-1:0]   w_pri;
            logic [WGAIN_W-1:0]  w_gain;
            logic [TIME_W-1:0]   w_time;
            logic [LOOPS_W-1:0]  w_loops;
            bit                  only_playing;
            bit                  have_victim;
            bit                  have_free;
            int unsigned         victim;
            int unsigned         taken;
            entry_t              e;

            res = '0;
            if (r.mode == MODE_WRITE)
            begin
                voices[r.index] = r.entry;
                res.count = alloc_count;
                return res;
            end

            span         = (scan_len > MAX_SOURCES) ? MAX_SOURCES : scan_len;
            w_pri        = INIT_WEAK_PRI;
            w_gain       = INIT_WEAK_GAIN;
            w_time       = r.now;
            w_loops      = '0;
            only_playing = 1'b1;
            have_victim  = 1'b0;
            have_free    = 1'b0;
            victim       = 0;
            taken        = 0;

            for (int k = 0; k < span && !have_free; k++)
            begin
                e = voices[k];
                if (!e.locked)
                begin
                    if (!e.active)
                    begin
                        have_free = 1'b1;
                        taken     = k;
                    end
                    else if (e.playing)
                    begin
                        // Playing voices only count while no stopped voice has been met.
                        if (only_playing && e.priority_val < r.req_pri &&
                            (e.priority_val < w_pri ||
                             (!e.looping && (e.gain < w_gain || e.time_ms < w_time))))
                        begin
                            w_pri       = e.priority_val;
                            w_time      = e.time_ms;
                            w_gain      = e.gain;
                            victim      = k;
                            have_victim = 1'b1;
                        end
                    end
                    else
                    begin
                        only_playing = 1'b0;
                        if (!have_victim || e.loops > w_loops || e.priority_val < w_pri ||
                            e.time_ms < w_time)
                        begin
                            w_pri       = e.priority_val;
                            w_time      = e.time_ms;
                            w_loops     = e.loops;
                            victim      = k;
                            have_victim = 1'b1;
                        end
                    end
                end
            end

            if (!have_free && have_victim)
            begin
                have_free = 1'b1;
                taken     = victim;
            end
            if (have_free)
            begin
                voices[taken]        = '0;
                voices[taken].active = 1'b1;
                alloc_count          = alloc_count + 1'b1;
                res.granted          = 1'b1;
                res.slot             = SLOT_W'(taken);
            end
            res.count = alloc_count;
            return res;
        endfunction

        function void note_request(voice_req_t r);
            grants_due.push_back(predict_allocation(r));
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_grant(result_t got);
            result_t want;

            if (grants_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual granted=%0b slot=%0d count=%0d",
                         $time, got.granted, got.slot, got.count);
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted)
                report("granted", want.granted, got.granted);
            if (got.slot !== want.slot)
                report("slot", want.slot, got.slot);
            if (got.count !== want.count)
                report("active_count", want.count, got.count);
        endfunction

    endclass

endpackage

>>> verif/testbench.sv
// Top of the audio voice allocator testbench: clock, reset, request and result
// handshakes, scan length changes and the watchdog. Depends on ava_pkg,
// ava_tb_pkg and audio_voice_allocator.
`timescale 1ns / 1ps

module testbench;

    import ava_pkg::*;
    import ava_tb_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 155;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [CFG_W-1:0]   cfg_write_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [SLOT_W-1:0]  entry_index;
    logic               entry_locked;
    logic               entry_active;
    logic               entry_playing;
    logic               entry_looping;
    logic [PRI_W-1:0]   entry_priority;
    logic [GAIN_W-1:0]  entry_gain;
    logic [TIME_W-1:0]  entry_time;
    logic [LOOPS_W-1:0] entry_loop_count;
    logic [PRI_W-1:0]   request_priority;
    logic [TIME_W-1:0]  now_time;
    logic               out_valid;
    logic               out_ready;
    logic               granted;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] active_count;

    voice_scoreboard sb = new();
    bit              idle_on = 1'b1;
    bit              hold_off_req = 1'b0;
    int unsigned     scan_plan [12] = '{8, 3, 16, 1, 64, 0, 127, 5, 65, 12, 2, 40};

    always #4 clk = ~clk;

    audio_voice_allocator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .entry_index      (entry_index),
        .entry_locked     (entry_locked),
        .entry_active     (entry_active),
        .entry_playing    (entry_playing),
        .entry_looping    (entry_looping),
        .entry_priority   (entry_priority),
        .entry_gain       (entry_gain),
        .entry_time       (entry_time),
        .entry_loop_count (entry_loop_count),
        .request_priority (request_priority),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .granted          (granted),
        .slot             (slot),
        .active_count     (active_count)
    );

    function automatic voice_req_t make_write(int unsigned idx, bit lk, bit act, bit ply,
                                              bit lp, int unsigned pri, int unsigned gain,
                                              logic [TIME_W-1:0] tm, int unsigned loops);
        voice_req_t r;

        r                    = '0;
        r.mode               = MODE_WRITE;
        r.index              = SLOT_W'(idx);
        r.entry.locked       = lk;
        r.entry.active       = act;
        r.entry.playing      = ply;
        r.entry.looping      = lp;
        r.entry.priority_val = PRI_W'(pri);
        r.entry.gain         = GAIN_W'(gain);
        r.entry.time_ms      = tm;
        r.entry.loops        = LOOPS_W'(loops);
        return r;
    endfunction

    function automatic voice_req_t make_alloc(int unsigned req, logic [TIME_W-1:0] now);
        voice_req_t r;

        r         = '0;
        r.mode    = MODE_ALLOC;
        r.req_pri = PRI_W'(req);
        r.now     = now;
        return r;
    endfunction

    // Writes mostly land inside the scanned range and mostly mark voices busy, so
    // that allocations have to weigh up victims rather than take a free voice.
    function automatic voice_req_t random_request(int unsigned span);
        voice_req_t r;

        r.mode = ($urandom_range(99) < 35) ? MODE_ALLOC : MODE_WRITE;
        if (span == 0 || $urandom_range(7) == 0)
            r.index = SLOT_W'($urandom_range(MAX_SOURCES - 1));
        else
            r.index = SLOT_W'($urandom_range(span - 1));
        r.entry.locked       = ($urandom_range(99) < 10);
        r.entry.active       = ($urandom_range(99) < 88);
        r.entry.playing      = ($urandom_range(99) < 55);
        r.entry.looping      = ($urandom_range(99) < 35);
        r.entry.priority_val = PRI_W'($urandom_range(7));
        case ($urandom_range(3))
            0:       r.entry.gain = GAIN_W'($urandom_range(8));
            1:       r.entry.gain = 16'hFFFF - GAIN_W'($urandom_range(8));
            default: r.entry.gain = GAIN_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       r.entry.time_ms = TIME_W'($urandom_range(40));
            1:       r.entry.time_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(40));
            default: r.entry.time_ms = TIME_W'($urandom);
        endcase
        r.entry.loops = ($urandom_range(1) == 0) ? LOOPS_W'($urandom_range(3))
                                                 : LOOPS_W'($urandom);
        r.req_pri = PRI_W'($urandom_range(7));
        case ($urandom_range(3))
            0:       r.now = TIME_W'($urandom_range(40));
            1:       r.now = 32'hFFFF_FFFF - TIME_W'($urandom_range(40));
            default: r.now = TIME_W'($urandom);
        endcase
        return r;
    endfunction

    // Returns at the edge where the transaction is accepted.
    task automatic drive_request(input voice_req_t r);
        if (idle_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= r.mode;
        entry_index      <= r.index;
        entry_locked     <= r.entry.locked;
        entry_active     <= r.entry.active;
        entry_playing    <= r.entry.playing;
        entry_looping    <= r.entry.looping;
        entry_priority   <= r.entry.priority_val;
        entry_gain       <= r.entry.gain;
        entry_time       <= r.entry.time_ms;
        entry_loop_count <= r.entry.loops;
        request_priority <= r.req_pri;
        now_time         <= r.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // The scan length is only changed once every outstanding grant has been seen.
    task automatic set_scan_length(input int unsigned value);
        in_valid <= 1'b0;
        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= CFG_W'(value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_scan_length(CFG_W'(value));
    endtask

    initial
    begin : stimulus
        int unsigned span;

        rst_n            <= 1'b0;
        cfg_write_en     <= 1'b0;
        cfg_write_data   <= '0;
        in_valid         <= 1'b0;
        mode             <= MODE_WRITE;
        entry_index      <= '0;
        entry_locked     <= 1'b0;
        entry_active     <= 1'b0;
        entry_playing    <= 1'b0;
        entry_looping    <= 1'b0;
        entry_priority   <= '0;
        entry_gain       <= '0;
        entry_time       <= '0;
        entry_loop_count <= '0;
        request_priority <= '0;
        now_time         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: free voices are taken in order.
        drive_request(make_alloc(0, 32'h0));
        drive_request(make_alloc(7, 32'hFFFF_FFFF));
        drive_request(make_write(63, 1, 1, 1, 1, 7, 16'hFFFF, 32'hFFFF_FFFF, 255));

        set_scan_length(4);
        drive_request(make_write(0, 1, 1, 1, 1, 7, 16'hFFFF, 32'hFFFF_FFFF, 255));
        drive_request(make_write(1, 0, 1, 1, 0, 0, 16'h0000, 32'h0, 0));
        drive_request(make_write(2, 0, 1, 1, 1, 3, 16'h8000, 32'd100, 1));
        drive_request(make_write(3, 0, 1, 1, 0, 7, 16'h1000, 32'd5, 7));
        // A request of the lowest priority can steal nothing that is playing.
        drive_request(make_alloc(0, 32'hFFFF_FFFF));
        drive_request(make_alloc(7, 32'hFFFF_FFFF));
        drive_request(make_write(2, 0, 1, 0, 0, 5, 16'h0100, 32'd50, 200));
        drive_request(make_alloc(4, 32'h0));
        drive_request(make_write(1, 1, 1, 0, 0, 0, 16'h0, 32'h0, 0));
        drive_request(make_write(2, 1, 0, 0, 0, 0, 16'h0, 32'h0, 0));
        drive_request(make_write(3, 1, 0, 1, 0, 0, 16'h0, 32'h0, 0));
        // Every scanned voice is locked, so nothing is granted.
        drive_request(make_alloc(7, 32'd1234));
        drive_request(make_write(3, 0, 1, 1, 0, 2, 16'hFFFF, 32'hFFFF_FFFF, 0));
        drive_request(make_alloc(3, 32'hFFFF_FFFF));

        for (int p = 0; p < 12; p++)
        begin
            set_scan_length(scan_plan[p]);
            span    = (scan_plan[p] > MAX_SOURCES) ? MAX_SOURCES : scan_plan[p];
            idle_on = (p != 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 50)
                    hold_off_req = 1'b1;
                drive_request(random_request(span));
            end
        end
        in_valid <= 1'b0;

        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.mismatches == 0 && sb.grants_due.size() == 0)
            $display("audio_voice_allocator regression: pass");
        else
            $display("audio_voice_allocator regression: fail");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold_left;
        result_t     got;

        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.granted = granted;
                got.slot    = slot;
                got.count   = active_count;
                sb.check_grant(got);
            end
            // A long hold-off lets the output register fill and back up the input.
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 28);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("audio_voice_allocator regression: fail");
        $finish;
    end

endmodule
